// ----- rtl/core/agss_pkg.sv -----
package agss_pkg;

    // Field widths
    localparam int SpeedW   = 8;
    localparam int PeriodW  = 10;
    localparam int StepW    = 6;
    localparam int CountW   = 12;
    localparam int GearW    = 3;
    localparam int QueueW   = 4;
    localparam int CoilW    = 4;
    localparam int IdxW     = 3;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 12;
    localparam int InDataW  = 16;
    localparam int OutDataW = 8;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_GEAR_PERIOD     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SPEED_STEP      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_STEPS_PER_SHIFT = 2'd2;

    // Register reset values
    localparam logic [PeriodW-1:0] GEAR_PERIOD_RST     = 10'd200;
    localparam logic [StepW-1:0]   SPEED_STEP_RST      = 6'd10;
    localparam logic [CountW-1:0]  STEPS_PER_SHIFT_RST = 12'd450;

    // Gear codes
    localparam logic [GearW-1:0] GEAR_START = 3'd0;
    localparam logic [GearW-1:0] GEAR_ONE   = 3'd1;
    localparam logic [GearW-1:0] GEAR_TWO   = 3'd2;
    localparam logic [GearW-1:0] GEAR_FOUR  = 3'd4;
    localparam logic [GearW-1:0] GEAR_FIVE  = 3'd5;
    localparam logic [GearW-1:0] GEAR_SIX   = 3'd6;

    localparam logic [QueueW-1:0] QUEUE_MAX = 4'd15;

    // Shifter states
    typedef enum logic [1:0] {
        SH_START = 2'd0,
        SH_WAIT  = 2'd1,
        SH_UP    = 2'd2,
        SH_DOWN  = 2'd3
    } sh_state_t;

    // Half-step coil patterns, bit0 = first coil
    localparam logic [CoilW-1:0] FWD_PATTERN [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };
    localparam logic [CoilW-1:0] REV_PATTERN [8] = '{
        4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
    };

    // Queue add saturating at the top
    function automatic logic [QueueW-1:0] sat_add(input logic [QueueW-1:0] q,
                                                  input logic [1:0] n);
        logic [QueueW:0] sum;
        begin
            sum = {1'b0, q} + {3'b000, n};
            sat_add = (sum > {1'b0, QUEUE_MAX}) ? QUEUE_MAX : sum[QueueW-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/auto_gear_shift_stepper_ctrl_unit.sv -----
// Gear selector with stepper shifter. One tick transaction in gives one result
// transaction out, which appears on the master side the next cycle unless
// stalled. A tick can be accepted on every cycle: the whole tick update is one
// pass of comparators, a small threshold multiply and counters between the state
// registers, and a two-entry output buffer lets input continue while one result
// waits; s_tready drops only when both entries are full. Configuration writes
// take effect on the next clock edge and must be made while the block is idle.
module auto_gear_shift_stepper_ctrl_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port
    input  logic                          cfg_wen,
    input  logic [agss_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [agss_pkg::CfgDataW-1:0] cfg_data,
    // Tick input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] speed, [8] up_request, [9] down_request, [10] accel_jump, rest zero
    input  logic [agss_pkg::InDataW-1:0]  s_tdata,
    // Result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] gear, [6:3] coils, [7] busy_res
    output logic [agss_pkg::OutDataW-1:0] m_tdata
);
    import agss_pkg::*;

    // Configuration registers
    logic [PeriodW-1:0] gear_period_reg;
    logic [StepW-1:0]   speed_step_reg;
    logic [CountW-1:0]  steps_per_shift_reg;

    // Tick state
    logic [GearW-1:0]  gear_fsm_reg,     gear_fsm_next;
    sh_state_t         sh_state_reg,     sh_state_next;
    logic [QueueW-1:0] up_queue_reg,     up_queue_next;
    logic [QueueW-1:0] down_queue_reg,   down_queue_next;
    logic [IdxW-1:0]   step_index_reg,   step_index_next;
    logic [CountW-1:0] step_count_reg,   step_count_next;
    logic [PeriodW-1:0] period_count_reg, period_count_next;
    logic [CoilW-1:0]  coil_latch_reg,   coil_latch_next;
    logic [GearW-1:0]  gear_latch_reg,   gear_latch_next;
    logic              busy_latch_reg,   busy_latch_next;

    // Output buffer
    logic                main_valid_reg, skid_valid_reg;
    logic [OutDataW-1:0] main_data_reg,  skid_data_reg;

    logic                push, pop;
    logic [OutDataW-1:0] result;

    // Input fields
    logic [SpeedW-1:0] speed;
    logic              up_request, down_request, accel_jump;

    // Selector intermediates
    logic [PeriodW-1:0] period_inc;
    logic               evaluate;
    logic [8:0]         thr_up, thr_down, speed_ext;
    logic [GearW-1:0]   gear_minus;
    logic               only_up, only_down, go_up, go_down;
    logic [QueueW-1:0]  uq_sel, dq_sel;

    assign speed        = s_tdata[7:0];
    assign up_request   = s_tdata[8];
    assign down_request = s_tdata[9];
    assign accel_jump   = s_tdata[10];

    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_period_reg     <= GEAR_PERIOD_RST;
            speed_step_reg      <= SPEED_STEP_RST;
            steps_per_shift_reg <= STEPS_PER_SHIFT_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_GEAR_PERIOD:     gear_period_reg     <= cfg_data[PeriodW-1:0];
                CFG_SPEED_STEP:      speed_step_reg      <= cfg_data[StepW-1:0];
                CFG_STEPS_PER_SHIFT: steps_per_shift_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Selector thresholds
    assign gear_minus = gear_fsm_reg - 3'd1;
    assign thr_up     = 9'(speed_step_reg) * 9'(gear_fsm_reg);
    assign thr_down   = 9'(speed_step_reg) * 9'(gear_minus);
    assign speed_ext  = {1'b0, speed};
    assign only_up    = up_request && !down_request;
    assign only_down  = down_request && !up_request;
    assign go_up   = (gear_fsm_reg >= GEAR_ONE) && (gear_fsm_reg <= GEAR_FIVE) &&
                     ((speed_ext >= thr_up) || only_up);
    assign go_down = (gear_fsm_reg >= GEAR_TWO) && (gear_fsm_reg <= GEAR_SIX) &&
                     ((speed_ext < thr_down) || only_down);

    assign period_inc = period_count_reg + 10'd1;
    assign evaluate   = period_inc >= gear_period_reg;

    // One tick: selector then shifter
    always_comb
    begin
        gear_fsm_next     = gear_fsm_reg;
        sh_state_next     = sh_state_reg;
        step_index_next   = step_index_reg;
        step_count_next   = step_count_reg;
        coil_latch_next   = coil_latch_reg;
        gear_latch_next   = gear_latch_reg;
        busy_latch_next   = busy_latch_reg;
        period_count_next = evaluate ? '0 : period_inc;
        uq_sel            = up_queue_reg;
        dq_sel            = down_queue_reg;

        // Gear selection
        if (evaluate)
        begin
            if (gear_fsm_reg == GEAR_START)
            begin
                uq_sel        = '0;
                dq_sel        = '0;
                gear_fsm_next = GEAR_ONE;
            end
            else if (go_up)
            begin
                dq_sel = '0;
                if (accel_jump && (gear_fsm_reg <= GEAR_FOUR))
                begin
                    uq_sel        = sat_add(up_queue_reg, 2'd2);
                    gear_fsm_next = gear_fsm_reg + 3'd2;
                end
                else
                begin
                    uq_sel        = sat_add(up_queue_reg, 2'd1);
                    gear_fsm_next = gear_fsm_reg + 3'd1;
                end
            end
            else if (go_down)
            begin
                uq_sel        = '0;
                dq_sel        = sat_add(down_queue_reg, 2'd1);
                gear_fsm_next = gear_minus;
            end
            if ((gear_fsm_next >= GEAR_ONE) && (gear_fsm_next <= GEAR_SIX))
                gear_latch_next = gear_fsm_next;
        end

        up_queue_next   = uq_sel;
        down_queue_next = dq_sel;

        // Shifter
        unique case (sh_state_reg)
            SH_START: sh_state_next = SH_WAIT;
            SH_WAIT:
            begin
                if (uq_sel != '0)
                begin
                    up_queue_next   = uq_sel - 4'd1;
                    busy_latch_next = 1'b1;
                    sh_state_next   = SH_UP;
                end
                else if (dq_sel != '0)
                begin
                    down_queue_next = dq_sel - 4'd1;
                    busy_latch_next = 1'b1;
                    sh_state_next   = SH_DOWN;
                end
                else
                    busy_latch_next = 1'b0;
            end
            SH_UP, SH_DOWN:
            begin
                if (step_count_reg < steps_per_shift_reg)
                begin
                    step_index_next = step_index_reg + 3'd1;
                    step_count_next = step_count_reg + 12'd1;
                end
                else
                begin
                    step_count_next = '0;
                    busy_latch_next = 1'b0;
                    sh_state_next   = SH_WAIT;
                end
            end
            default: ;
        endcase

        // Coil drive follows the pattern at the new index
        if (sh_state_next == SH_UP)
            coil_latch_next = FWD_PATTERN[step_index_next];
        else if (sh_state_next == SH_DOWN)
            coil_latch_next = REV_PATTERN[step_index_next];

        result = {busy_latch_next, coil_latch_next, gear_latch_next};
    end

    // State registers advance on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_fsm_reg     <= GEAR_START;
            sh_state_reg     <= SH_START;
            up_queue_reg     <= '0;
            down_queue_reg   <= '0;
            step_index_reg   <= '0;
            step_count_reg   <= '0;
            period_count_reg <= '0;
            coil_latch_reg   <= '0;
            gear_latch_reg   <= '0;
            busy_latch_reg   <= 1'b0;
        end
        else if (push)
        begin
            gear_fsm_reg     <= gear_fsm_next;
            sh_state_reg     <= sh_state_next;
            up_queue_reg     <= up_queue_next;
            down_queue_reg   <= down_queue_next;
            step_index_reg   <= step_index_next;
            step_count_reg   <= step_count_next;
            period_count_reg <= period_count_next;
            coil_latch_reg   <= coil_latch_next;
            gear_latch_reg   <= gear_latch_next;
            busy_latch_reg   <= busy_latch_next;
        end
    end

    // Two-entry output buffer: main drives the port, skid catches a stalled result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                main_valid_reg <= push;
        end
        else if (push)
        begin
            if (!main_valid_reg)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the buffer
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                main_data_reg <= skid_data_reg;
            else if (push)
                main_data_reg <= result;
        end
        else if (push)
        begin
            if (!main_valid_reg)
                main_data_reg <= result;
            else
                skid_data_reg <= result;
        end
    end

endmodule

// ----- rtl/core/agss_checker.sv -----
module agss_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [agss_pkg::OutDataW-1:0] m_tdata
);
    import agss_pkg::*;

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Input back-pressure only when a result is waiting on the port
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // An accepted tick is always followed by a valid result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted transaction produced no result");

    // Coils can only be driven once a gear has been selected
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[6:3] != 4'd0) |-> (m_tdata[2:0] != GEAR_START))
        else $error("coils driven before first gear");

    // Gear code stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= GEAR_SIX))
        else $error("gear out of range");

endmodule

bind auto_gear_shift_stepper_ctrl_unit agss_checker u_agss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import agss_pkg::*;

    localparam int StallLimit = 2000;
    localparam int HoldCycles = 400;
    localparam int HoldPhase  = 3;
    localparam int NumPhases  = 8;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [GearW-1:0] gear;
        logic [CoilW-1:0] coils;
        logic             busy;
    } shift_result_t;

    // Gear selector and shifter predictor with its queue of awaited results
    class gear_shift_scoreboard;
        logic [PeriodW-1:0] period_reg;
        logic [StepW-1:0]   step_reg;
        logic [CountW-1:0]  shift_len_reg;
        logic [GearW-1:0]   gear_state;
        sh_state_t          shifter;
        logic [QueueW-1:0]  up_q;
        logic [QueueW-1:0]  down_q;
        logic [IdxW-1:0]    coil_idx;
        logic [CountW-1:0]  step_cnt;
        logic [PeriodW-1:0] period_cnt;
        logic [CoilW-1:0]   coil_out;
        logic [GearW-1:0]   gear_out;
        logic               busy_out;
        shift_result_t      awaited[$];
        int                 errors;

        function new();
            period_reg    = GEAR_PERIOD_RST;
            step_reg      = SPEED_STEP_RST;
            shift_len_reg = STEPS_PER_SHIFT_RST;
            gear_state    = GEAR_START;
            shifter       = SH_START;
            up_q          = '0;
            down_q        = '0;
            coil_idx      = '0;
            step_cnt      = '0;
            period_cnt    = '0;
            coil_out      = '0;
            gear_out      = '0;
            busy_out      = 1'b0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                CFG_GEAR_PERIOD:     period_reg    = val[PeriodW-1:0];
                CFG_SPEED_STEP:      step_reg      = val[StepW-1:0];
                CFG_STEPS_PER_SHIFT: shift_len_reg = val[CountW-1:0];
                default: ;
            endcase
        endfunction

        // Queue count, held at the top
        function logic [QueueW-1:0] queue_add(logic [QueueW-1:0] q, int n);
            int sum;
            sum = int'(q) + n;
            if (sum > int'(QUEUE_MAX))
                return QUEUE_MAX;
            return sum[QueueW-1:0];
        endfunction

        function void select_gear(logic [SpeedW-1:0] spd, logic up, logic down, logic jump);
            int   up_thr;
            int   down_thr;
            logic only_up;
            logic only_down;
            logic go_up;
            logic go_down;
            only_up   = up && !down;
            only_down = down && !up;
            if (gear_state == GEAR_START)
            begin
                up_q       = '0;
                down_q     = '0;
                gear_state = GEAR_ONE;
            end
            else if (gear_state <= GEAR_SIX)
            begin
                up_thr   = int'(step_reg) * int'(gear_state);
                down_thr = int'(step_reg) * (int'(gear_state) - 1);
                go_up    = (gear_state <= GEAR_FIVE) && ((int'(spd) >= up_thr) || only_up);
                go_down  = (gear_state >= GEAR_TWO) && ((int'(spd) < down_thr) || only_down);
                if (go_up)
                begin
                    down_q = '0;
                    // two-gear jump only from gears one to four
                    if (jump && gear_state <= GEAR_FOUR)
                    begin
                        up_q       = queue_add(up_q, 2);
                        gear_state = gear_state + 3'd2;
                    end
                    else
                    begin
                        up_q       = queue_add(up_q, 1);
                        gear_state = gear_state + 3'd1;
                    end
                end
                else if (go_down)
                begin
                    up_q       = '0;
                    down_q     = queue_add(down_q, 1);
                    gear_state = gear_state - 3'd1;
                end
            end
            if (gear_state >= GEAR_ONE && gear_state <= GEAR_SIX)
                gear_out = gear_state;
        endfunction

        function void run_shifter();
            case (shifter)
                SH_START: shifter = SH_WAIT;
                SH_WAIT:
                begin
                    // up shifts are served before down shifts
                    if (up_q != '0)
                    begin
                        up_q     = up_q - 1'b1;
                        busy_out = 1'b1;
                        shifter  = SH_UP;
                    end
                    else if (down_q != '0)
                    begin
                        down_q   = down_q - 1'b1;
                        busy_out = 1'b1;
                        shifter  = SH_DOWN;
                    end
                    else
                        busy_out = 1'b0;
                end
                default:
                begin
                    if (step_cnt < shift_len_reg)
                    begin
                        coil_idx = coil_idx + 1'b1;
                        step_cnt = step_cnt + 1'b1;
                    end
                    else
                    begin
                        step_cnt = '0;
                        busy_out = 1'b0;
                        shifter  = SH_WAIT;
                    end
                end
            endcase
            if (shifter == SH_UP)
                coil_out = FWD_PATTERN[coil_idx];
            else if (shifter == SH_DOWN)
                coil_out = REV_PATTERN[coil_idx];
        endfunction

        function void note_tick(logic [InDataW-1:0] d);
            shift_result_t r;
            period_cnt = period_cnt + 1'b1;
            if (period_cnt >= period_reg)
            begin
                period_cnt = '0;
                select_gear(d[7:0], d[8], d[9], d[10]);
            end
            run_shifter();
            r.gear  = gear_out;
            r.coils = coil_out;
            r.busy  = busy_out;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [OutDataW-1:0] d);
            shift_result_t r;
            if (awaited.size() == 0)
            begin
                $error("result 0x%h with no tick awaiting it", d);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (d[2:0] !== r.gear)
            begin
                $error("gear: expected %0d, actual %0d", r.gear, d[2:0]);
                errors++;
            end
            if (d[6:3] !== r.coils)
            begin
                $error("coils: expected 0x%h, actual 0x%h", r.coils, d[6:3]);
                errors++;
            end
            if (d[7] !== r.busy)
            begin
                $error("busy_res: expected %0d, actual %0d", r.busy, d[7]);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_wen   = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // [7:0] speed, [8] up_request, [9] down_request, [10] accel_jump, rest zero
    logic [InDataW-1:0]  s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // [2:0] gear, [6:3] coils, [7] busy_res
    logic [OutDataW-1:0] m_tdata;

    gear_shift_scoreboard sb;
    idle_mode_t           mode     = IDLE_NONE;
    bit                   hold_req = 1'b0;

    // Random phase settings
    int unsigned phase_gp  [NumPhases] = '{3, 1, 2, 5, 1023, 1, 0, 200};
    int unsigned phase_ss  [NumPhases] = '{10, 1, 63, 25, 33, 63, 40, 10};
    int unsigned phase_sps [NumPhases] = '{5, 1, 12, 3, 4095, 4095, 0, 450};
    int unsigned phase_n   [NumPhases] = '{250, 250, 200, 250, 100, 150, 150, 250};
    idle_mode_t  phase_mode[NumPhases] = '{IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH,
                                           IDLE_SRC, IDLE_SINK, IDLE_BOTH, IDLE_NONE};

    auto_gear_shift_stepper_ctrl_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit sender_gap();
        case (mode)
            IDLE_SRC:  return $urandom_range(99) < 62;
            IDLE_BOTH: return $urandom_range(99) < 32;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit sink_ready();
        case (mode)
            IDLE_SINK: return $urandom_range(99) >= 62;
            IDLE_BOTH: return $urandom_range(99) >= 32;
            default:   return 1'b1;
        endcase
    endfunction

    // Monitor: note accepted ticks, then check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_tick(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else
                m_tready <= sink_ready();
        end
    end

    // Watchdog on cycles without any transaction
    initial
    begin : watchdog
        int idle_cnt;
        idle_cnt = 0;
        while (idle_cnt < StallLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic set_config(input int unsigned gp, input int unsigned ss,
                              input int unsigned sps);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_GEAR_PERIOD;
        cfg_data  <= gp[CfgDataW-1:0];
        sb.write_reg(CFG_GEAR_PERIOD, gp[CfgDataW-1:0]);
        @(posedge clk);
        cfg_index <= CFG_SPEED_STEP;
        cfg_data  <= ss[CfgDataW-1:0];
        sb.write_reg(CFG_SPEED_STEP, ss[CfgDataW-1:0]);
        @(posedge clk);
        cfg_index <= CFG_STEPS_PER_SHIFT;
        cfg_data  <= sps[CfgDataW-1:0];
        sb.write_reg(CFG_STEPS_PER_SHIFT, sps[CfgDataW-1:0]);
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic send_tick(input logic [SpeedW-1:0] spd, input logic up,
                             input logic down, input logic jump);
        while (sender_gap())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, jump, down, up, spd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Speeds mostly around the gear thresholds, sometimes anywhere
    task automatic send_random_tick(input int unsigned ss);
        int unsigned       top;
        logic [SpeedW-1:0] spd;
        top = ss * 7;
        if (top > 255)
            top = 255;
        if ($urandom_range(7) == 0)
            spd = SpeedW'($urandom_range(255));
        else
            spd = SpeedW'($urandom_range(top));
        send_tick(spd, $urandom_range(5) == 0, $urandom_range(5) == 0,
                  $urandom_range(2) == 0);
    endtask

    // Sender pauses until every awaited result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: selector evaluated every tick, short shifts
        set_config(1, 10, 2);
        mode = IDLE_NONE;
        send_tick(8'd0,   1'b0, 1'b0, 1'b0);   // leave start, gear one
        send_tick(8'd0,   1'b0, 1'b1, 1'b0);   // down button in gear one
        send_tick(8'd255, 1'b0, 1'b0, 1'b0);
        send_tick(8'd255, 1'b0, 1'b0, 1'b1);   // jump two
        send_tick(8'd255, 1'b0, 1'b0, 1'b1);   // jump to six
        send_tick(8'd255, 1'b1, 1'b1, 1'b1);   // six: both buttons, nothing
        send_tick(8'd0,   1'b0, 1'b0, 1'b0);
        send_tick(8'd0,   1'b1, 1'b0, 1'b1);   // five: up wins, jump ignored
        send_tick(8'd60,  1'b0, 1'b1, 1'b0);   // down button only
        send_tick(8'd50,  1'b0, 1'b0, 1'b1);
        send_tick(8'd50,  1'b0, 1'b0, 1'b0);   // exactly on the down threshold
        send_tick(8'd49,  1'b0, 1'b0, 1'b0);
        send_tick(8'd40,  1'b0, 1'b0, 1'b0);
        send_tick(8'd39,  1'b0, 1'b0, 1'b0);
        send_tick(8'd25,  1'b1, 1'b1, 1'b0);
        send_tick(8'd25,  1'b1, 1'b1, 1'b0);   // both buttons in band
        send_tick(8'd10,  1'b0, 1'b0, 1'b0);
        send_tick(8'd9,   1'b0, 1'b0, 1'b1);
        send_tick(8'd10,  1'b0, 1'b0, 1'b1);   // up threshold exact, jump
        wait_drain();

        // Zero gear period and zero steps per shift
        set_config(0, 10, 0);
        repeat (6) send_random_tick(10);
        wait_drain();

        // Random phases
        for (int p = 0; p < NumPhases; p++)
        begin
            set_config(phase_gp[p], phase_ss[p], phase_sps[p]);
            mode = phase_mode[p];
            for (int i = 0; i < int'(phase_n[p]); i++)
            begin
                if (p == HoldPhase && i == 20)
                    hold_req = 1'b1;
                send_random_tick(phase_ss[p]);
            end
            wait_drain();
        end

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
